// ===== src/tardf_pkg.sv =====
package tardf_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [8:0] BLOCK_LAST = 9'd511;
    localparam logic [8:0] NAME_LEN   = 9'd100;
    localparam logic [8:0] SIZE_FIRST = 9'd124;
    localparam logic [8:0] SIZE_LAST  = 9'd135;
    localparam logic [8:0] TYPE_POS   = 9'd156;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_DIR   = 8'h35;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ENDED   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OCT_SKIP   = 2'd0,
        OCT_DIGITS = 2'd1,
        OCT_DONE   = 2'd2
    } t_oct;

    typedef enum logic [2:0] {
        K_NAME = 3'd0,
        K_DIR  = 3'd1,
        K_FILE = 3'd2,
        K_DATA = 3'd3,
        K_END  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_result;

    // results of one byte, r0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_emit;

    function automatic t_emit push(t_emit e, t_kind k, logic [31:0] v, logic l);
        t_emit o;
        t_result r;
        o = e;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        if (e.cnt == 2'd0) begin
            o.r0 = r;
        end else begin
            o.r1 = r;
        end
        o.cnt = e.cnt + 2'd1;
        return o;
    endfunction

endpackage

// ===== src/tardf_parser.sv =====
module tardf_parser
    import tardf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_emit      o_emit
);

    logic [8:0]             r_block_offset, n_block_offset;
    t_phase                 r_phase, n_phase;
    logic                   r_name_ended, n_name_ended;
    t_oct                   r_oct, n_oct;
    logic [31:0]            r_size_accum, n_size_accum;
    logic [7:0]             r_entry_type, n_entry_type;
    logic [31:0]            r_bytes_rem, n_bytes_rem;
    logic [32:0]            r_padded_rem, n_padded_rem;
    logic [COUNT_WIDTH-1:0] r_file_count, n_file_count;

    logic  digit;
    logic  is_file;
    t_emit emit;

    assign digit = (i_byte >= CH_ZERO) && (i_byte <= CH_SEVEN);

    always_comb begin
        n_block_offset = r_block_offset;
        n_phase        = r_phase;
        n_name_ended   = r_name_ended;
        n_oct          = r_oct;
        n_size_accum   = r_size_accum;
        n_entry_type   = r_entry_type;
        n_bytes_rem    = r_bytes_rem;
        n_padded_rem   = r_padded_rem;
        n_file_count   = r_file_count;
        emit           = '0;
        is_file        = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_block_offset == 9'd0) begin
                    n_name_ended = 1'b0;
                    n_oct        = OCT_SKIP;
                    n_size_accum = '0;
                    n_entry_type = '0;
                end
                // empty name marks the end of the archive
                if (r_block_offset == 9'd0 && i_byte == 8'd0) begin
                    n_phase = PH_ENDED;
                end else begin
                    if (r_block_offset < NAME_LEN && !n_name_ended) begin
                        if (i_byte == 8'd0) begin
                            n_name_ended = 1'b1;
                        end else begin
                            emit = push(emit, K_NAME, {24'd0, i_byte}, 1'b0);
                        end
                    end
                    if (r_block_offset >= SIZE_FIRST && r_block_offset <= SIZE_LAST) begin
                        unique case (n_oct)
                            OCT_SKIP: begin
                                if (i_byte != CH_SPACE && i_byte != CH_ZERO) begin
                                    if (digit) begin
                                        n_size_accum = {29'd0, i_byte[2:0]};
                                        n_oct        = OCT_DIGITS;
                                    end else begin
                                        n_oct = OCT_DONE;
                                    end
                                end
                            end
                            OCT_DIGITS: begin
                                if (digit) begin
                                    n_size_accum = {n_size_accum[28:0], i_byte[2:0]};
                                end else begin
                                    n_oct = OCT_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (r_block_offset == TYPE_POS) begin
                        n_entry_type = i_byte;
                    end
                    if (r_block_offset == BLOCK_LAST) begin
                        is_file = (n_entry_type == CH_ZERO) || (n_entry_type == 8'd0);
                        if (n_entry_type == CH_DIR) begin
                            emit = push(emit, K_DIR, 32'd0, 1'b0);
                        end else if (is_file) begin
                            emit = push(emit, K_FILE, n_size_accum, 1'b0);
                            if (r_file_count != {COUNT_WIDTH{1'b1}}) begin
                                n_file_count = r_file_count + COUNT_WIDTH'(1);
                            end
                        end
                        n_bytes_rem    = is_file ? n_size_accum : 32'd0;
                        // round up to whole blocks in 33 bits so it never wraps
                        n_padded_rem   = ({1'b0, n_size_accum} + 33'd511)
                                         & ~33'd511;
                        n_block_offset = '0;
                        n_phase        = (n_padded_rem != 33'd0) ? PH_PAYLOAD : PH_HEADER;
                    end else begin
                        n_block_offset = r_block_offset + 9'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_bytes_rem != 32'd0) begin
                    n_bytes_rem = r_bytes_rem - 32'd1;
                    emit = push(emit, K_DATA, {24'd0, i_byte}, r_bytes_rem == 32'd1);
                end
                if (r_padded_rem != 33'd0) begin
                    n_padded_rem = r_padded_rem - 33'd1;
                end
                if (n_padded_rem == 33'd0) begin
                    n_phase        = PH_HEADER;
                    n_block_offset = '0;
                end
            end
            default: ;
        endcase

        if (i_eos) begin
            emit = push(emit, K_END, 32'(n_file_count), 1'b0);
            n_block_offset = '0;
            n_phase        = PH_HEADER;
            n_name_ended   = 1'b0;
            n_oct          = OCT_SKIP;
            n_size_accum   = '0;
            n_entry_type   = '0;
            n_bytes_rem    = '0;
            n_padded_rem   = '0;
            n_file_count   = '0;
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_offset <= '0;
            r_phase        <= PH_HEADER;
            r_name_ended   <= 1'b0;
            r_oct          <= OCT_SKIP;
            r_size_accum   <= '0;
            r_entry_type   <= '0;
            r_bytes_rem    <= '0;
            r_padded_rem   <= '0;
            r_file_count   <= '0;
        end else if (i_fire) begin
            r_block_offset <= n_block_offset;
            r_phase        <= n_phase;
            r_name_ended   <= n_name_ended;
            r_oct          <= n_oct;
            r_size_accum   <= n_size_accum;
            r_entry_type   <= n_entry_type;
            r_bytes_rem    <= n_bytes_rem;
            r_padded_rem   <= n_padded_rem;
            r_file_count   <= n_file_count;
        end
    end

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_padded_rem != 33'd0)
        else $error("payload phase with nothing left to skip");

    a_data_within_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> {1'b0, r_bytes_rem} <= r_padded_rem)
        else $error("more data bytes left than payload bytes");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_fire && !i_eos |=> r_file_count >= $past(r_file_count))
        else $error("file count dropped without stream end");

endmodule

// ===== src/tardf_out_buf.sv =====
module tardf_out_buf
    import tardf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_emit       i_emit,
    output logic        o_space,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_of_file
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       pop;

    assign pop = (r_cnt != 2'd0) && m_axis_tready;
    // a new byte may land only when the buffer is empty or drains this cycle
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && m_axis_tready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_cnt   = i_emit.cnt;
            n_slot0 = i_emit.r0;
            n_slot1 = i_emit.r1;
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_slot0.value;
    assign m_axis_tuser  = r_slot0.kind;
    assign m_axis_tlast  = r_slot0.last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer overfilled");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_space)
        else $error("results loaded over pending results");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && m_axis_tready && !i_load |=> r_cnt == 2'd1)
        else $error("second result lost after first transaction");

endmodule

// ===== src/tar_archive_stream_deframer.sv =====
// path: an accepted byte passes the input register, then the result register, before its first
// result is shown; a second result follows once the first has been taken
// throughput: one byte per cycle while m_axis_tready holds; a byte with two results holds the
// input until its first result is taken, because the single result port drains one transaction per cycle
// reset: synchronous active-low i_rst_n returns the parser to the start of a header
// and empties the input and result registers
module tar_archive_stream_deframer
    import tardf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_of_file
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       space;
    logic       fire;
    t_emit      emit;

    assign fire          = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    tardf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_emit  (emit)
    );

    tardf_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_emit        (emit),
        .o_space       (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
